[src/tea_pkg.sv]
// Shared types and constants for the TEA cipher pipeline.
package tea_pkg;

	localparam int WORD_W = 32;
	localparam int KEY_WORDS = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

	// Key register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] KEY0_IDX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] KEY1_IDX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] KEY2_IDX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] KEY3_IDX = 3'd3;

	// Operation codes carried in the kind bit
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	typedef word_t key_set_t [KEY_WORDS];

	// One block in flight between cells
	typedef struct packed {
		logic  kind;
		word_t a;
		word_t b;
	} tea_item_t;

	// TEA round function: ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb)
	function automatic word_t tea_mix(word_t x, word_t sum, word_t ka, word_t kb);
		word_t left_term;
		word_t mid_term;
		word_t right_term;
		left_term  = (x << 4) + ka;
		mid_term   = x + sum;
		right_term = (x >> 5) + kb;
		return left_term ^ mid_term ^ right_term;
	endfunction

endpackage

[src/tea_block_cipher_unit.sv]
// Top level of the TEA block cipher: key registers and the chain of half-round cells.
//
// TEA block cipher unit. Each transaction on the input channel carries one 64-bit block
// as first_word/second_word plus kind (0 encrypt, 1 decrypt); each produces exactly one
// transaction on the output channel, in order. The 128-bit key lives in four registers
// written through cfg_we/cfg_index/cfg_wdata (indexes 0..3, others ignored); write them
// only while no block is in flight. The datapath is a chain of 2*ROUNDS identical cells,
// one per half-round (one word update each). An accepted block passes through every cell
// in turn before it reaches the output, and a new block is taken every cycle unless a
// stall on the output has filled the chain.
// Each cell has its own valid bit and a ready that looks only at its
// downstream neighbor, so a stall on the output closes bubbles upstream first and the
// input keeps accepting until the chain is completely full. The round sums are
// elaboration-time constants per cell: encryption uses delta*(round+1), decryption
// starts at delta*ROUNDS (0xC6EF3720 for 32 rounds) and counts down, all mod 2^32.
module tea_block_cipher_unit import tea_pkg::*; #(
	parameter int ROUNDS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic [WORD_W-1:0]    first_word,
	input  logic [WORD_W-1:0]    second_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_W-1:0]    result_first,
	output logic [WORD_W-1:0]    result_second
);

	localparam int STAGES = 2 * ROUNDS;

	key_set_t  key_q;
	logic      stage_valid [STAGES+1];
	logic      stage_ready [STAGES+1];
	tea_item_t stage_data  [STAGES+1];

	// Key registers: hold until written, drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEY_WORDS; k++) begin
				key_q[k] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				KEY0_IDX: key_q[0] <= cfg_wdata;
				KEY1_IDX: key_q[1] <= cfg_wdata;
				KEY2_IDX: key_q[2] <= cfg_wdata;
				KEY3_IDX: key_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Head of the chain is the input port
	assign stage_valid[0]   = in_valid;
	assign stage_data[0]    = '{kind: kind, a: first_word, b: second_word};
	assign in_stall         = !stage_ready[0];

	// Tail of the chain is the output register
	assign stage_ready[STAGES] = !out_stall;
	assign out_valid           = stage_valid[STAGES];
	assign result_first        = stage_data[STAGES].a;
	assign result_second       = stage_data[STAGES].b;

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		localparam int          RND     = i / 2;
		localparam logic        HALF    = 1'((i % 2));
		localparam logic [63:0] ENC_P   = 64'(TEA_DELTA) * 64'(RND + 1);
		localparam logic [63:0] DEC_P   = 64'(TEA_DELTA) * 64'(ROUNDS - RND);

		tea_cell #(
			.HALF    (HALF),
			.SUM_ENC (ENC_P[31:0]),
			.SUM_DEC (DEC_P[31:0])
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.keys     (key_q),
			.up_valid (stage_valid[i]),
			.up_data  (stage_data[i]),
			.up_ready (stage_ready[i]),
			.dn_valid (stage_valid[i+1]),
			.dn_data  (stage_data[i+1]),
			.dn_ready (stage_ready[i+1])
		);
	end

	// An accepted block lands in the first cell on the next edge
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> stage_valid[1])
		else $error("accepted block missing from first cell");

	// A free output must open the whole chain back to the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	// A key write takes effect on the following edge
	a_key0_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == KEY0_IDX) |=> (key_q[0] == $past(cfg_wdata)))
		else $error("key word 0 not updated");

	a_key3_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == KEY3_IDX) |=> (key_q[3] == $past(cfg_wdata)))
		else $error("key word 3 not updated");

endmodule

[src/tea_cell.sv]
// One half-round cell of the TEA pipeline: updates one word of the block.
module tea_cell import tea_pkg::*; #(
	parameter logic        HALF    = 1'b0,
	parameter logic [31:0] SUM_ENC = 32'h0,
	parameter logic [31:0] SUM_DEC = 32'h0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  key_set_t  keys,
	input  logic      up_valid,
	input  tea_item_t up_data,
	output logic      up_ready,
	output logic      dn_valid,
	output tea_item_t dn_data,
	input  logic      dn_ready
);

	logic      valid_q;
	tea_item_t data_q;
	logic      update_a;
	word_t     src_word;
	word_t     dst_word;
	word_t     ka;
	word_t     kb;
	word_t     sum;
	word_t     mixed;
	word_t     new_word;
	tea_item_t next_item;

	// Encrypt: first half updates a, second updates b. Decrypt runs the halves reversed.
	assign update_a = (up_data.kind == HALF);
	assign src_word = update_a ? up_data.b : up_data.a;
	assign dst_word = update_a ? up_data.a : up_data.b;
	assign ka       = update_a ? keys[0] : keys[2];
	assign kb       = update_a ? keys[1] : keys[3];
	assign sum      = (up_data.kind == OP_DECRYPT) ? SUM_DEC : SUM_ENC;
	assign mixed    = tea_mix(src_word, sum, ka, kb);
	assign new_word = (up_data.kind == OP_DECRYPT) ? dst_word - mixed : dst_word + mixed;

	always_comb begin
		next_item = up_data;
		if (update_a) begin
			next_item.a = new_word;
		end else begin
			next_item.b = new_word;
		end
	end

	// Take a new item when empty or when the neighbor takes ours
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= next_item;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

[dv/tb_tea_block_cipher_unit.sv]
// Self-checking testbench for the TEA block cipher unit with a built-in cipher predictor.
`timescale 1ns / 1ps

module tb_tea_block_cipher_unit;
	import tea_pkg::*;

	localparam int TEA_ROUNDS = 32;
	// Pipeline depth: one cell per half-round
	localparam int PIPE_DEPTH = 2 * TEA_ROUNDS;
	// Cycles with no transaction on either channel before the run is declared hung
	localparam int STUCK_LIMIT = 5000;
	localparam int ITEMS_PER_KEY = 210;

	typedef struct packed {
		word_t first;
		word_t second;
	} block_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic                 kind;
	logic [WORD_W-1:0]    first_word;
	logic [WORD_W-1:0]    second_word;
	logic                 out_valid;
	logic                 out_stall;
	logic [WORD_W-1:0]    result_first;
	logic [WORD_W-1:0]    result_second;

	// Shadow copy of the key registers, kept in step with every write
	word_t  key_reg [KEY_WORDS];
	// Cipher outputs predicted for accepted blocks, oldest first
	block_t pending_blocks [$];
	block_t want;

	int error_count;
	int enc_count;
	int dec_count;
	int key_loads;
	int stuck_cycles;
	int send_idle_pct;
	int recv_stall_pct;

	tea_block_cipher_unit #(.ROUNDS(TEA_ROUNDS)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.first_word   (first_word),
		.second_word  (second_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_first (result_first),
		.result_second(result_second)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// TEA round function, computed at the 32-bit word width so every add wraps
	function automatic word_t feistel_f(word_t x, word_t sum, word_t ka, word_t kb);
		return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
	endfunction

	// Predict the full TEA_ROUNDS-round encryption or decryption under the shadow key
	function automatic block_t tea_crypt(logic op, word_t a, word_t b);
		word_t  sum;
		block_t res;
		if (op == OP_ENCRYPT) begin
			sum = '0;
			for (int n = 0; n < TEA_ROUNDS; n++) begin
				sum = sum + TEA_DELTA;
				a = a + feistel_f(b, sum, key_reg[KEY0_IDX[1:0]], key_reg[KEY1_IDX[1:0]]);
				b = b + feistel_f(a, sum, key_reg[KEY2_IDX[1:0]], key_reg[KEY3_IDX[1:0]]);
			end
		end else begin
			// Start from delta * rounds and walk the sums back down
			sum = TEA_DELTA * word_t'(TEA_ROUNDS);
			for (int n = 0; n < TEA_ROUNDS; n++) begin
				b = b - feistel_f(a, sum, key_reg[KEY2_IDX[1:0]], key_reg[KEY3_IDX[1:0]]);
				a = a - feistel_f(b, sum, key_reg[KEY0_IDX[1:0]], key_reg[KEY1_IDX[1:0]]);
				sum = sum - TEA_DELTA;
			end
		end
		res.first  = a;
		res.second = b;
		return res;
	endfunction

	// Bias toward the corners: zero, all ones, walking one and walking zero
	function automatic word_t rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return word_t'(1) << $urandom_range(WORD_W - 1);
			3: return ~(word_t'(1) << $urandom_range(WORD_W - 1));
			default: return word_t'($urandom);
		endcase
	endfunction

	// Present one block and hold it until the unit takes it. Called and returns at a
	// rising edge; the transaction completes at the edge on return.
	task automatic send_block(input logic op, input word_t a, input word_t b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			// Idle cycle: drop valid and scramble the payload lines
			in_valid    <= 1'b0;
			kind        <= logic'($urandom_range(1));
			first_word  <= word_t'($urandom);
			second_word <= word_t'($urandom);
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= op;
		first_word  <= a;
		second_word <= b;
		// Sample stall mid-cycle, where it is settled for the coming edge
		@(negedge clk);
		while (in_stall) @(negedge clk);
		pending_blocks.push_back(tea_crypt(op, a, b));
		if (op == OP_ENCRYPT) enc_count++;
		else dec_count++;
		@(posedge clk);
	endtask

	// Stop sending and wait until every predicted block has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_blocks.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Drive one register write; the caller lowers cfg_we after its last write
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input word_t data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		if (idx <= KEY3_IDX) key_reg[idx[1:0]] = data;
	endtask

	task automatic load_key(input key_set_t keys);
		for (int i = 0; i < KEY_WORDS; i++) cfg_write(CFG_IDX_W'(i), keys[i]);
		cfg_we <= 1'b0;
		key_loads++;
	endtask

	// Key registers come out of reset as zero
	task automatic test_reset_key();
		send_block(OP_ENCRYPT, '0, '0);
		send_block(OP_DECRYPT, '0, '0);
		send_block(OP_ENCRYPT, '1, '1);
		send_block(OP_DECRYPT, '1, '1);
		wait_drained();
	endtask

	// Corner data words under a mixed key and an all-ones key, plus one round trip
	task automatic test_directed_extremes();
		key_set_t mixed_key;
		key_set_t ones_key;
		block_t   cipher;
		mixed_key = '{32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210};
		ones_key  = '{'1, '1, '1, '1};
		load_key(mixed_key);
		send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
		send_block(OP_DECRYPT, 32'h8000_0000, 32'h0000_0001);
		send_block(OP_ENCRYPT, 32'h7fff_ffff, 32'hffff_fffe);
		send_block(OP_DECRYPT, 32'h7fff_ffff, 32'hffff_fffe);
		send_block(OP_ENCRYPT, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
		send_block(OP_DECRYPT, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
		cipher = tea_crypt(OP_ENCRYPT, 32'hdead_beef, 32'h0bad_f00d);
		send_block(OP_ENCRYPT, 32'hdead_beef, 32'h0bad_f00d);
		send_block(OP_DECRYPT, cipher.first, cipher.second);
		wait_drained();
		load_key(ones_key);
		send_block(OP_ENCRYPT, '0, '1);
		send_block(OP_DECRYPT, '0, '1);
		send_block(OP_ENCRYPT, '1, '0);
		send_block(OP_DECRYPT, '1, '0);
		wait_drained();
	endtask

	// Writes to indexes past the last key word must leave the key untouched
	task automatic test_unknown_index();
		for (int i = KEY_WORDS; i < (1 << CFG_IDX_W); i++)
			cfg_write(CFG_IDX_W'(i), word_t'($urandom));
		cfg_we <= 1'b0;
		send_block(OP_ENCRYPT, word_t'($urandom), word_t'($urandom));
		send_block(OP_DECRYPT, word_t'($urandom), word_t'($urandom));
		wait_drained();
	endtask

	// Random blocks under three keys with the given idling profile. Most traffic is
	// encrypt/decrypt round trips so the inverse path sees real ciphertexts.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		key_set_t keys;
		block_t   mid;
		logic     op;
		word_t    a;
		word_t    b;
		int       sent;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				// Middle setting hits the extremes: each word all zeros or all ones
				if (k == 1) keys[i] = $urandom_range(1) ? '1 : '0;
				else keys[i] = rand_word();
			end
			load_key(keys);
			sent = 0;
			while (sent < ITEMS_PER_KEY) begin
				op = logic'($urandom_range(1));
				a  = rand_word();
				b  = rand_word();
				if ($urandom_range(99) < 60) begin
					// Round trip: the second block undoes the first
					mid = tea_crypt(op, a, b);
					send_block(op, a, b);
					send_block(~op, mid.first, mid.second);
					sent += 2;
				end else begin
					send_block(op, a, b);
					sent++;
				end
			end
			wait_drained();
		end
	endtask

	// Receiver: raise stall at random per the current profile
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Result check: sample mid-cycle, compare the transaction against the oldest prediction
	initial begin
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_blocks.size() == 0) begin
					$display("%0t: unexpected result %h %h", $time, result_first,
						result_second);
					error_count++;
				end else begin
					want = pending_blocks.pop_front();
					if (result_first !== want.first) begin
						$display("%0t: result_first mismatch: expected %h, got %h",
							$time, want.first, result_first);
						error_count++;
					end
					if (result_second !== want.second) begin
						$display("%0t: result_second mismatch: expected %h, got %h",
							$time, want.second, result_second);
						error_count++;
					end
				end
			end
		end
	end

	// Watchdog: bail out when neither channel moves for too long
	initial begin
		stuck_cycles = 0;
		while (stuck_cycles < STUCK_LIMIT) begin
			@(negedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
			else stuck_cycles++;
		end
		$display("watchdog: no transaction for %0d cycles", STUCK_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		// Hold every input at a known value from time zero
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		kind           = OP_ENCRYPT;
		first_word     = '0;
		second_word    = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		error_count    = 0;
		enc_count      = 0;
		dec_count      = 0;
		key_loads      = 0;
		for (int i = 0; i < KEY_WORDS; i++) key_reg[i] = '0;
		repeat (3) @(posedge clk);
		// Release reset away from the active edge
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_reset_key();
		test_directed_extremes();
		test_unknown_index();
		test_random_traffic(35, 88);
		test_random_traffic(88, 35);
		test_random_traffic(0, 0);

		// Let the pipeline run empty to catch any stray result
		wait_drained();
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		if (pending_blocks.size() != 0) begin
			$display("%0d predicted blocks never came out", pending_blocks.size());
			error_count++;
		end
		$display("Ran %0d encrypt and %0d decrypt blocks over %0d key loads,", enc_count,
			dec_count, key_loads);
		$display("with reset key, ignored indexes and three idle/stall profiles.");
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
